/* design/kwsm_pkg.sv */
// Package for the k-way sorted merge block.
// Holds the command codes, the result word type and the sequencer state type.
// No dependencies.
package kwsm_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 3;
  localparam int LANE_W = 2;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_CLOSE = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] merged_value;
    logic              status;
    logic              run_last;
    logic              merge_done;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

endpackage

/* design/kwsm_in_if.sv */
// Input channel of the k-way sorted merge block: one command word per handshake.
// Depends on kwsm_pkg for field widths.
interface kwsm_in_if;
  logic                               valid;
  logic                               ready;
  logic                               command;
  logic [kwsm_pkg::LANE_W-1:0]        lane;
  logic signed [kwsm_pkg::DATA_W-1:0] value;

  modport source (output valid, output command, output lane, output value, input ready);
  modport sink   (input valid, input command, input lane, input value, output ready);
endinterface

/* design/kwsm_out_if.sv */
// Output channel of the k-way sorted merge block: one result word per handshake.
// Depends on kwsm_pkg for field widths.
interface kwsm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [kwsm_pkg::DATA_W-1:0] merged_value;
  logic                               status;
  logic                               run_last;
  logic                               merge_done;

  modport source (output valid, output merged_value, output status, output run_last,
                  output merge_done, input ready);
  modport sink   (input valid, input merged_value, input status, input run_last,
                  input merge_done, output ready);
endinterface

/* design/kwsm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module kwsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/k_way_sorted_merge.sv */
// Top level of the k-way sorted merge: lane buffers in one RAM and a sequencer
// that walks the lane heads with a single shared signed comparator.
// Depends on kwsm_pkg, kwsm_in_if, kwsm_out_if and kwsm_ram.
//
//   Channel      Direction  Contents
//   item         in         command, lane, value
//   result       out        merged_value, status, run_last, merge_done
//   lanes_used   in         write enable and 3-bit data, no read-back
//
// A word is accepted in IDLE, then each result costs a scan of the used lanes plus
// a pop of the winner in EMIT; a last scan and a flush end the word. When the batch
// ends, the pop goes straight to the flush; a rejected push goes there from IDLE.
// Reset is synchronous and clears all lanes; the buffer RAM itself is not cleared.
// A result waits in a pending register until the next one is known, so run_last
// can be set; a stalled output holds the sequencer but not an accepted item.
module k_way_sorted_merge #(
  parameter int LANES      = 4,
  parameter int LANE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         lanes_used_we,
  input  logic [kwsm_pkg::CFG_W-1:0]   lanes_used_wdata,
  kwsm_in_if.sink                      item,
  kwsm_out_if.source                   result
);

  localparam int LB = $clog2(LANES);
  localparam int DB = $clog2(LANE_DEPTH);
  localparam int CB = $clog2(LANE_DEPTH + 1);
  localparam int UB = $clog2(LANES + 1);
  localparam int SW = CB + 1;
  localparam int LW = (LB > kwsm_pkg::LANE_W) ? LB : kwsm_pkg::LANE_W;
  localparam int AW = LB + DB;
  localparam int RAM_DEPTH = LANES * (2 ** DB);

  kwsm_pkg::state_t state;

  logic [kwsm_pkg::CFG_W-1:0] lanes_used;
  logic [DB-1:0]              head [LANES];
  logic [CB-1:0]              count [LANES];
  logic [LANES-1:0]           closed;

  logic [UB-1:0]              idx;
  logic                       pv;
  logic [LB-1:0]              pidx;
  logic                       any_head;
  logic                       rdy;
  logic [LB-1:0]              best;
  logic signed [kwsm_pkg::DATA_W-1:0] bv;

  kwsm_pkg::result_t cand;
  logic              cand_valid;
  kwsm_pkg::result_t out_q;
  logic              out_valid;

  logic [UB-1:0] used;
  logic [LW-1:0] lane_w;
  logic [LB-1:0] lane_idx;
  logic          lane_ok;
  logic          accept;
  logic          is_push;
  logic          full;
  logic [SW-1:0] wr_sum;
  logic [DB-1:0] wr_off;
  logic          ram_we;
  logic          overflow;
  logic [LB-1:0] idx_l;
  logic [LB-1:0] rd_lane;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [kwsm_pkg::DATA_W-1:0] ram_rdata;
  logic          all_done;
  logic          out_free;
  logic          out_load;

  always_comb begin
    if (lanes_used == '0) begin
      used = UB'(1);
    end else if (int'(lanes_used) > LANES) begin
      used = UB'(LANES);
    end else begin
      used = UB'(lanes_used);
    end
  end

  assign accept   = item.valid && item.ready;
  assign lane_w   = LW'(item.lane);
  assign lane_idx = lane_w[LB-1:0];
  assign lane_ok  = int'(item.lane) < int'(used);
  assign is_push  = item.command == kwsm_pkg::CMD_PUSH;
  assign full     = count[lane_idx] == CB'(LANE_DEPTH);

  always_comb begin
    wr_sum = SW'(head[lane_idx]) + SW'(count[lane_idx]);
    if (wr_sum >= SW'(LANE_DEPTH)) begin
      wr_sum = wr_sum - SW'(LANE_DEPTH);
    end
    wr_off = wr_sum[DB-1:0];
  end

  assign ram_we    = accept && lane_ok && is_push && !closed[lane_idx] && !full;
  assign overflow  = accept && lane_ok && is_push && !closed[lane_idx] && full;
  assign ram_waddr = {lane_idx, wr_off};

  assign idx_l     = idx[LB-1:0];
  assign rd_lane   = (idx < used) ? idx_l : '0;
  assign ram_raddr = {rd_lane, head[rd_lane]};

  kwsm_ram #(
    .WIDTH(kwsm_pkg::DATA_W),
    .DEPTH(RAM_DEPTH)
  ) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(item.value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // The batch ends when the pop of the winning head leaves every used lane
  // closed and empty.
  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < LANES; i++) begin
      if (i < int'(used)) begin
        if (LB'(i) == best) begin
          if (count[i] != CB'(1) || !closed[i]) all_done = 1'b0;
        end else begin
          if (count[i] != '0 || !closed[i]) all_done = 1'b0;
        end
      end
    end
  end

  assign out_free = !out_valid || result.ready;
  assign out_load = out_free && cand_valid &&
                    (state == kwsm_pkg::ST_EMIT || state == kwsm_pkg::ST_FLUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= kwsm_pkg::ST_IDLE;
      lanes_used <= kwsm_pkg::CFG_W'(4);
      for (int i = 0; i < LANES; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
      end
      closed     <= '0;
      cand_valid <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
      pv         <= 1'b0;
      any_head   <= 1'b0;
      rdy        <= 1'b1;
    end else begin
      if (lanes_used_we) begin
        lanes_used <= lanes_used_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        kwsm_pkg::ST_IDLE: begin
          if (accept) begin
            if (ram_we) begin
              count[lane_idx] <= count[lane_idx] + CB'(1);
            end
            if (lane_ok && !is_push) begin
              closed[lane_idx] <= 1'b1;
            end
            if (overflow) begin
              cand.merged_value <= item.value;
              cand.status       <= kwsm_pkg::STATUS_OVERFLOW;
              cand.run_last     <= 1'b1;
              cand.merge_done   <= 1'b0;
              cand_valid        <= 1'b1;
              state             <= kwsm_pkg::ST_FLUSH;
            end else begin
              idx      <= '0;
              pv       <= 1'b0;
              any_head <= 1'b0;
              rdy      <= 1'b1;
              state    <= kwsm_pkg::ST_SCAN;
            end
          end
        end
        kwsm_pkg::ST_SCAN: begin
          if (idx < used) begin
            pv   <= 1'b1;
            pidx <= idx_l;
            idx  <= idx + UB'(1);
          end else begin
            pv <= 1'b0;
          end
          if (pv) begin
            if (count[pidx] == '0) begin
              if (!closed[pidx]) rdy <= 1'b0;
            end else begin
              if (!any_head || $signed(ram_rdata) < bv) begin
                best <= pidx;
                bv   <= $signed(ram_rdata);
              end
              any_head <= 1'b1;
            end
          end
          if (idx == used && !pv) begin
            if (rdy && any_head) begin
              state <= kwsm_pkg::ST_EMIT;
            end else begin
              if (rdy) closed <= '0;
              state <= kwsm_pkg::ST_FLUSH;
            end
          end
        end
        kwsm_pkg::ST_EMIT: begin
          if (out_free) begin
            if (cand_valid) begin
              out_q <= cand;
            end
            cand.merged_value <= bv;
            cand.status       <= kwsm_pkg::STATUS_OK;
            cand.run_last     <= 1'b0;
            cand.merge_done   <= all_done;
            cand_valid        <= 1'b1;
            head[best]  <= (head[best] == DB'(LANE_DEPTH - 1)) ? '0 : head[best] + DB'(1);
            count[best] <= count[best] - CB'(1);
            if (all_done) begin
              closed <= '0;
              state  <= kwsm_pkg::ST_FLUSH;
            end else begin
              idx      <= '0;
              pv       <= 1'b0;
              any_head <= 1'b0;
              rdy      <= 1'b1;
              state    <= kwsm_pkg::ST_SCAN;
            end
          end
        end
        kwsm_pkg::ST_FLUSH: begin
          if (!cand_valid) begin
            state <= kwsm_pkg::ST_IDLE;
          end else if (out_free) begin
            out_q      <= '{merged_value: cand.merged_value, status: cand.status,
                            run_last: 1'b1, merge_done: cand.merge_done};
            cand_valid <= 1'b0;
            state      <= kwsm_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= kwsm_pkg::ST_IDLE;
        end
      endcase
    end
  end

  assign item.ready          = state == kwsm_pkg::ST_IDLE;
  assign result.valid        = out_valid;
  assign result.merged_value = $signed(out_q.merged_value);
  assign result.status       = out_q.status;
  assign result.run_last     = out_q.run_last;
  assign result.merge_done   = out_q.merge_done;

  // An idle sequencer never holds a pending result.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    item.ready |-> !cand_valid)
    else $error("pending result held while accepting input");

  // A rejected push is always the only and last result of its word.
  a_overflow_flags: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status) |-> (result.run_last && !result.merge_done))
    else $error("overflow result carries wrong flags");

  // Flushing the pending result closes the run on the output.
  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    (state == kwsm_pkg::ST_FLUSH && cand_valid && out_free) |=>
      (result.valid && result.run_last))
    else $error("flushed result not marked as last");

  // Lane 0 never holds more words than its buffer.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count[0] <= CB'(LANE_DEPTH))
    else $error("lane fill count beyond buffer depth");

endmodule
